FILE: design/lcg_pkg.sv
// shared constants and codes for the locomotion command gate
`timescale 1ns / 1ps
package lcg_pkg;

    localparam int VEL_BITS_DEF    = 16;
    localparam int TICK_BITS_DEF   = 32;
    localparam int TARGET_MODE_DEF = 500;

    localparam int OP_BITS     = 4;
    localparam int ACT_BITS    = 3;
    localparam int VERD_BITS   = 2;
    localparam int PHASE_BITS  = 3;
    localparam int MODE_BITS   = 16;
    localparam int DUR_BITS    = 16;
    localparam int LIM_BITS    = 15;
    localparam int FAIL_BITS   = 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [OP_BITS-1:0] OP_TICK      = 4'd0;
    localparam logic [OP_BITS-1:0] OP_ENABLE    = 4'd1;
    localparam logic [OP_BITS-1:0] OP_DISABLE   = 4'd2;
    localparam logic [OP_BITS-1:0] OP_COMMAND   = 4'd3;
    localparam logic [OP_BITS-1:0] OP_STOP      = 4'd4;
    localparam logic [OP_BITS-1:0] OP_INIT      = 4'd5;
    localparam logic [OP_BITS-1:0] OP_ID_REPLY  = 4'd6;
    localparam logic [OP_BITS-1:0] OP_SET_REPLY = 4'd7;
    localparam logic [OP_BITS-1:0] OP_VEL_REPLY = 4'd8;
    localparam logic [OP_BITS-1:0] OP_QUERY     = 4'd9;

    localparam logic [ACT_BITS-1:0] ACT_NONE      = 3'd0;
    localparam logic [ACT_BITS-1:0] ACT_QUERY     = 3'd1;
    localparam logic [ACT_BITS-1:0] ACT_SET_MODE  = 3'd2;
    localparam logic [ACT_BITS-1:0] ACT_SEND_VEL  = 3'd3;
    localparam logic [ACT_BITS-1:0] ACT_ZERO_STOP = 3'd4;
    localparam logic [ACT_BITS-1:0] ACT_STOP_MOVE = 3'd5;

    localparam logic [VERD_BITS-1:0] VERD_ACCEPTED     = 2'd0;
    localparam logic [VERD_BITS-1:0] VERD_ENABLE_FALSE = 2'd1;
    localparam logic [VERD_BITS-1:0] VERD_IF_DISABLED  = 2'd2;
    localparam logic [VERD_BITS-1:0] VERD_NOT_READY    = 2'd3;

    localparam logic [PHASE_BITS-1:0] PH_IDLE      = 3'd0;
    localparam logic [PHASE_BITS-1:0] PH_CHECKING  = 3'd1;
    localparam logic [PHASE_BITS-1:0] PH_SETTING   = 3'd2;
    localparam logic [PHASE_BITS-1:0] PH_VERIFYING = 3'd3;
    localparam logic [PHASE_BITS-1:0] PH_READY     = 3'd4;
    localparam logic [PHASE_BITS-1:0] PH_ERROR     = 3'd5;

    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_FORWARD  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_SIDE     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_TURN     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_STREAM_TMO   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_DRIVE_DUR    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_FAIL_LIMIT   = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_STOP_DUR     = 3'd6;

    localparam logic [LIM_BITS-1:0]  RST_MAX_FORWARD = 15'd500;
    localparam logic [LIM_BITS-1:0]  RST_MAX_SIDE    = 15'd300;
    localparam logic [LIM_BITS-1:0]  RST_MAX_TURN    = 15'd800;
    localparam logic [DUR_BITS-1:0]  RST_STREAM_TMO  = 16'd6;
    localparam logic [DUR_BITS-1:0]  RST_DRIVE_DUR   = 16'd20;
    localparam logic [FAIL_BITS-1:0] RST_FAIL_LIMIT  = 8'd3;
    localparam logic [DUR_BITS-1:0]  RST_STOP_DUR    = 16'd20;

    localparam logic signed [MODE_BITS-1:0] MODE_UNKNOWN = -16'sd1;
    localparam logic [FAIL_BITS-1:0] FAIL_SAT = 8'hFF;

endpackage

FILE: design/lcg_evt_if.sv
// event channel interface
`timescale 1ns / 1ps
interface lcg_evt_if
    import lcg_pkg::*;
#(
    parameter int VEL_BITS = VEL_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic [OP_BITS-1:0]          op;
    logic                        reply_ok;
    logic signed [MODE_BITS-1:0] mode_id;
    logic signed [MODE_BITS-1:0] mode_sub;
    logic                        cmd_enable;
    logic                        cmd_continuous;
    logic [DUR_BITS-1:0]         cmd_duration;
    logic signed [VEL_BITS-1:0]  forward_in;
    logic signed [VEL_BITS-1:0]  side_in;
    logic signed [VEL_BITS-1:0]  turn_in;

    modport source (
        output valid, op, reply_ok, mode_id, mode_sub, cmd_enable, cmd_continuous,
               cmd_duration, forward_in, side_in, turn_in,
        input  ready
    );
    modport sink (
        input  valid, op, reply_ok, mode_id, mode_sub, cmd_enable, cmd_continuous,
               cmd_duration, forward_in, side_in, turn_in,
        output ready
    );
endinterface

FILE: design/lcg_res_if.sv
// result channel interface
`timescale 1ns / 1ps
interface lcg_res_if
    import lcg_pkg::*;
#(
    parameter int VEL_BITS = VEL_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic [ACT_BITS-1:0]         action;
    logic signed [VEL_BITS-1:0]  forward_out;
    logic signed [VEL_BITS-1:0]  side_out;
    logic signed [VEL_BITS-1:0]  turn_out;
    logic [DUR_BITS-1:0]         duration_out;
    logic [VERD_BITS-1:0]        verdict;
    logic [PHASE_BITS-1:0]       init_phase;
    logic                        gate_ready;
    logic                        motion_active;
    logic signed [MODE_BITS-1:0] cached_mode_id;
    logic signed [MODE_BITS-1:0] cached_mode_sub;

    modport source (
        output valid, action, forward_out, side_out, turn_out, duration_out, verdict,
               init_phase, gate_ready, motion_active, cached_mode_id, cached_mode_sub,
        input  ready
    );
    modport sink (
        input  valid, action, forward_out, side_out, turn_out, duration_out, verdict,
               init_phase, gate_ready, motion_active, cached_mode_id, cached_mode_sub,
        output ready
    );
endinterface

FILE: design/lcg_cfg_if.sv
// configuration write channel interface
`timescale 1ns / 1ps
interface lcg_cfg_if
    import lcg_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

FILE: design/locomotion_command_gate.sv
// locomotion command gate top level: mode bring-up, command clamp, watchdog
//
//  channel | role   | transaction
//  --------+--------+-----------------------------------------------
//  evt     | sink   | one event (op and its operands)
//  res     | source | one result (action, velocities, status)
//  cfg     | sink   | one register write (index, data), always ready
//
//  throughput is one event per cycle while results are taken; an event passes
//  through the event register and then the result register
//  rst_n clears all control and status state and loads register defaults
//  a stalled result holds the result register; the event register holds one
//  more event, after which evt.ready drops until res.ready returns
`timescale 1ns / 1ps
module locomotion_command_gate
    import lcg_pkg::*;
#(
    parameter int VEL_BITS    = VEL_BITS_DEF,
    parameter int TICK_BITS   = TICK_BITS_DEF,
    parameter int TARGET_MODE = TARGET_MODE_DEF
)(
    input  logic       clk,
    input  logic       rst_n,
    lcg_evt_if.sink    evt,
    lcg_res_if.source  res,
    lcg_cfg_if.sink    cfg
);

    localparam int CW = ((VEL_BITS > LIM_BITS) ? VEL_BITS : LIM_BITS) + 2;
    localparam logic signed [MODE_BITS-1:0] TGT = MODE_BITS'(TARGET_MODE);

    // configuration registers
    logic [LIM_BITS-1:0]  max_fwd_reg, max_side_reg, max_turn_reg;
    logic [DUR_BITS-1:0]  stream_tmo_reg, drive_dur_reg, stop_dur_reg;
    logic [FAIL_BITS-1:0] fail_limit_reg;

    // event register
    logic                        evt_valid_reg;
    logic [OP_BITS-1:0]          op_reg;
    logic                        ok_reg;
    logic signed [MODE_BITS-1:0] mid_reg, msub_reg;
    logic                        en_reg, cont_reg;
    logic [DUR_BITS-1:0]         dur_in_reg;
    logic signed [VEL_BITS-1:0]  fwd_in_reg, side_in_reg, turn_in_reg;

    // gate state
    logic [PHASE_BITS-1:0]       phase_reg, phase_next;
    logic                        ready_reg, ready_next;
    logic                        enabled_reg, enabled_next;
    logic                        pending_reg, pending_next;
    logic                        active_reg, active_next;
    logic signed [VEL_BITS-1:0]  hfwd_reg, hfwd_next;
    logic signed [VEL_BITS-1:0]  hside_reg, hside_next;
    logic signed [VEL_BITS-1:0]  hturn_reg, hturn_next;
    logic [TICK_BITS-1:0]        tick_reg, tick_next;
    logic [TICK_BITS-1:0]        last_reg, last_next;
    logic                        have_reg, have_next;
    logic [TICK_BITS-1:0]        dl_reg, dl_next;
    logic                        dl_set_reg, dl_set_next;
    logic [FAIL_BITS-1:0]        fail_reg, fail_next;
    logic signed [MODE_BITS-1:0] kid_reg, kid_next;
    logic signed [MODE_BITS-1:0] ksub_reg, ksub_next;

    // result register
    logic                        res_valid_reg;
    logic [ACT_BITS-1:0]         act_reg, act_next;
    logic signed [VEL_BITS-1:0]  ofwd_reg, ofwd_next;
    logic signed [VEL_BITS-1:0]  oside_reg, oside_next;
    logic signed [VEL_BITS-1:0]  oturn_reg, oturn_next;
    logic [DUR_BITS-1:0]         odur_reg, odur_next;
    logic [VERD_BITS-1:0]        verd_reg, verd_next;

    logic                        fire;
    logic                        evt_take;
    logic                        busy;
    logic [TICK_BITS-1:0]        elapsed, span;
    logic                        stream_out, shot_out;
    logic [DUR_BITS-1:0]         shot_dur;
    logic [FAIL_BITS-1:0]        fail_inc;
    logic signed [VEL_BITS-1:0]  cfwd, cside, cturn;

    function automatic logic signed [VEL_BITS-1:0] clamp_vel(
        input logic signed [VEL_BITS-1:0] v,
        input logic [LIM_BITS-1:0]        lim
    );
        logic signed [CW-1:0] ve, le, nle;
        ve  = CW'(v);
        le  = signed'(CW'(lim));
        nle = -le;
        if (ve > le)
            return le[VEL_BITS-1:0];
        else if (ve < nle)
            return nle[VEL_BITS-1:0];
        else
            return v;
    endfunction

    assign fire      = evt_valid_reg && (!res_valid_reg || res.ready);
    assign evt.ready = !evt_valid_reg || fire;
    assign evt_take  = evt.valid && evt.ready;
    assign cfg.ready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_fwd_reg    <= RST_MAX_FORWARD;
            max_side_reg   <= RST_MAX_SIDE;
            max_turn_reg   <= RST_MAX_TURN;
            stream_tmo_reg <= RST_STREAM_TMO;
            drive_dur_reg  <= RST_DRIVE_DUR;
            fail_limit_reg <= RST_FAIL_LIMIT;
            stop_dur_reg   <= RST_STOP_DUR;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_MAX_FORWARD: max_fwd_reg    <= cfg.data[LIM_BITS-1:0];
                REG_MAX_SIDE:    max_side_reg   <= cfg.data[LIM_BITS-1:0];
                REG_MAX_TURN:    max_turn_reg   <= cfg.data[LIM_BITS-1:0];
                REG_STREAM_TMO:  stream_tmo_reg <= cfg.data[DUR_BITS-1:0];
                REG_DRIVE_DUR:   drive_dur_reg  <= cfg.data[DUR_BITS-1:0];
                REG_FAIL_LIMIT:  fail_limit_reg <= cfg.data[FAIL_BITS-1:0];
                REG_STOP_DUR:    stop_dur_reg   <= cfg.data[DUR_BITS-1:0];
                default: ;
            endcase
        end
    end

    // event register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            evt_valid_reg <= 1'b0;
        else if (evt_take)
            evt_valid_reg <= 1'b1;
        else if (fire)
            evt_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (evt_take)
        begin
            op_reg      <= evt.op;
            ok_reg      <= evt.reply_ok;
            mid_reg     <= evt.mode_id;
            msub_reg    <= evt.mode_sub;
            en_reg      <= evt.cmd_enable;
            cont_reg    <= evt.cmd_continuous;
            dur_in_reg  <= evt.cmd_duration;
            fwd_in_reg  <= evt.forward_in;
            side_in_reg <= evt.side_in;
            turn_in_reg <= evt.turn_in;
        end
    end

    // shared datapath terms
    assign busy       = (phase_reg == PH_CHECKING) || (phase_reg == PH_SETTING) ||
                        (phase_reg == PH_VERIFYING);
    assign elapsed    = tick_reg + TICK_BITS'(1) - last_reg;
    assign span       = dl_reg - last_reg;
    assign stream_out = have_reg && (elapsed > TICK_BITS'(stream_tmo_reg));
    assign shot_out   = dl_set_reg && (elapsed > span);
    assign shot_dur   = (dur_in_reg == '0) ? DUR_BITS'(1) : dur_in_reg;
    assign fail_inc   = (fail_reg == FAIL_SAT) ? fail_reg : fail_reg + FAIL_BITS'(1);
    assign cfwd       = clamp_vel(fwd_in_reg, max_fwd_reg);
    assign cside      = clamp_vel(side_in_reg, max_side_reg);
    assign cturn      = clamp_vel(turn_in_reg, max_turn_reg);

    // event decode and next state
    always_comb
    begin
        phase_next   = phase_reg;
        ready_next   = ready_reg;
        enabled_next = enabled_reg;
        pending_next = pending_reg;
        active_next  = active_reg;
        hfwd_next    = hfwd_reg;
        hside_next   = hside_reg;
        hturn_next   = hturn_reg;
        tick_next    = tick_reg;
        last_next    = last_reg;
        have_next    = have_reg;
        dl_next      = dl_reg;
        dl_set_next  = dl_set_reg;
        fail_next    = fail_reg;
        kid_next     = kid_reg;
        ksub_next    = ksub_reg;
        act_next     = ACT_NONE;
        ofwd_next    = '0;
        oside_next   = '0;
        oturn_next   = '0;
        odur_next    = '0;
        verd_next    = VERD_ACCEPTED;

        unique case (op_reg) inside
            OP_TICK:
            begin
                tick_next = tick_reg + TICK_BITS'(1);
                if (ready_reg && enabled_reg && pending_reg)
                begin
                    if (stream_out || shot_out)
                    begin
                        pending_next = 1'b0;
                        active_next  = 1'b0;
                        act_next     = ACT_ZERO_STOP;
                        odur_next    = stop_dur_reg;
                    end
                    else
                    begin
                        act_next   = ACT_SEND_VEL;
                        ofwd_next  = hfwd_reg;
                        oside_next = hside_reg;
                        oturn_next = hturn_reg;
                        odur_next  = drive_dur_reg;
                    end
                end
            end
            OP_ENABLE, OP_INIT:
            begin
                if (op_reg == OP_ENABLE)
                    enabled_next = 1'b1;
                if ((op_reg == OP_INIT || !ready_reg) && !busy)
                begin
                    ready_next   = 1'b0;
                    pending_next = 1'b0;
                    active_next  = 1'b0;
                    phase_next   = PH_CHECKING;
                    act_next     = ACT_QUERY;
                end
            end
            OP_DISABLE, OP_STOP:
            begin
                pending_next = 1'b0;
                active_next  = 1'b0;
                if (op_reg == OP_DISABLE)
                    enabled_next = 1'b0;
                act_next = ACT_STOP_MOVE;
            end
            OP_COMMAND:
            begin
                if (!en_reg)
                    verd_next = VERD_ENABLE_FALSE;
                else if (!enabled_reg)
                    verd_next = VERD_IF_DISABLED;
                else if (!ready_reg)
                    verd_next = VERD_NOT_READY;
                else
                begin
                    hfwd_next    = cfwd;
                    hside_next   = cside;
                    hturn_next   = cturn;
                    last_next    = tick_reg;
                    have_next    = 1'b1;
                    dl_set_next  = !cont_reg;
                    dl_next      = cont_reg ? '0 : tick_reg + TICK_BITS'(shot_dur);
                    pending_next = 1'b1;
                    active_next  = (cfwd != '0) || (cside != '0) || (cturn != '0);
                end
            end
            OP_ID_REPLY:
            begin
                if (phase_reg == PH_CHECKING || phase_reg == PH_VERIFYING)
                begin
                    if (!ok_reg || (phase_reg == PH_VERIFYING && mid_reg != TGT))
                    begin
                        ready_next   = 1'b0;
                        pending_next = 1'b0;
                        active_next  = 1'b0;
                        phase_next   = PH_ERROR;
                        kid_next     = MODE_UNKNOWN;
                        ksub_next    = MODE_UNKNOWN;
                    end
                    else if (mid_reg == TGT)
                    begin
                        ready_next = 1'b1;
                        phase_next = PH_READY;
                        fail_next  = '0;
                        kid_next   = TGT;
                        ksub_next  = MODE_UNKNOWN;
                    end
                    else
                    begin
                        phase_next = PH_SETTING;
                        kid_next   = mid_reg;
                        act_next   = ACT_SET_MODE;
                    end
                end
            end
            OP_SET_REPLY:
            begin
                if (phase_reg == PH_SETTING)
                begin
                    if (!ok_reg)
                    begin
                        ready_next   = 1'b0;
                        pending_next = 1'b0;
                        active_next  = 1'b0;
                        phase_next   = PH_ERROR;
                        kid_next     = MODE_UNKNOWN;
                        ksub_next    = MODE_UNKNOWN;
                    end
                    else
                    begin
                        phase_next = PH_VERIFYING;
                        act_next   = ACT_QUERY;
                    end
                end
            end
            OP_VEL_REPLY:
            begin
                if (ok_reg)
                    fail_next = '0;
                else
                begin
                    fail_next = fail_inc;
                    if (fail_inc >= fail_limit_reg && ready_reg)
                    begin
                        ready_next   = 1'b0;
                        pending_next = 1'b0;
                        active_next  = 1'b0;
                        phase_next   = PH_ERROR;
                        kid_next     = MODE_UNKNOWN;
                        ksub_next    = MODE_UNKNOWN;
                        act_next     = ACT_ZERO_STOP;
                        odur_next    = stop_dur_reg;
                    end
                end
            end
            OP_QUERY:
            begin
                if (ok_reg)
                begin
                    ready_next = (mid_reg == TGT);
                    phase_next = (mid_reg == TGT) ? PH_READY : PH_ERROR;
                    kid_next   = mid_reg;
                    ksub_next  = msub_reg;
                end
                else
                begin
                    ready_next = 1'b0;
                    phase_next = PH_ERROR;
                    kid_next   = MODE_UNKNOWN;
                    ksub_next  = MODE_UNKNOWN;
                end
            end
            default: ;
        endcase
    end

    // gate state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            ready_reg   <= 1'b0;
            enabled_reg <= 1'b0;
            pending_reg <= 1'b0;
            active_reg  <= 1'b0;
            hfwd_reg    <= '0;
            hside_reg   <= '0;
            hturn_reg   <= '0;
            tick_reg    <= '0;
            last_reg    <= '0;
            have_reg    <= 1'b0;
            dl_reg      <= '0;
            dl_set_reg  <= 1'b0;
            fail_reg    <= '0;
            kid_reg     <= MODE_UNKNOWN;
            ksub_reg    <= MODE_UNKNOWN;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            ready_reg   <= ready_next;
            enabled_reg <= enabled_next;
            pending_reg <= pending_next;
            active_reg  <= active_next;
            hfwd_reg    <= hfwd_next;
            hside_reg   <= hside_next;
            hturn_reg   <= hturn_next;
            tick_reg    <= tick_next;
            last_reg    <= last_next;
            have_reg    <= have_next;
            dl_reg      <= dl_next;
            dl_set_reg  <= dl_set_next;
            fail_reg    <= fail_next;
            kid_reg     <= kid_next;
            ksub_reg    <= ksub_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (fire)
            res_valid_reg <= 1'b1;
        else if (res.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            act_reg   <= act_next;
            ofwd_reg  <= ofwd_next;
            oside_reg <= oside_next;
            oturn_reg <= oturn_next;
            odur_reg  <= odur_next;
            verd_reg  <= verd_next;
        end
    end

    // status fields show the state left by the event in the result register
    assign res.valid           = res_valid_reg;
    assign res.action          = act_reg;
    assign res.forward_out     = ofwd_reg;
    assign res.side_out        = oside_reg;
    assign res.turn_out        = oturn_reg;
    assign res.duration_out    = odur_reg;
    assign res.verdict         = verd_reg;
    assign res.init_phase      = phase_reg;
    assign res.gate_ready      = ready_reg;
    assign res.motion_active   = active_reg;
    assign res.cached_mode_id  = kid_reg;
    assign res.cached_mode_sub = ksub_reg;

    // gate open only in the ready phase
    a_ready_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> (phase_reg == PH_READY))
        else $error("gate open outside ready phase");

    // motion only with a pending command
    a_active_pending: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> pending_reg)
        else $error("motion active with no pending command");

    // velocities only carried by a send velocity result
    a_vel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && act_reg != ACT_SEND_VEL) |->
            (ofwd_reg == '0 && oside_reg == '0 && oturn_reg == '0))
        else $error("velocity on a non-velocity result");

    // a good velocity reply clears the failure count
    a_fail_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && op_reg == OP_VEL_REPLY && ok_reg) |=> (fail_reg == '0))
        else $error("failure count not cleared");

    // each processed event yields a result on the next cycle
    a_res_follows: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> res_valid_reg)
        else $error("processed event produced no result");

endmodule

FILE: dv/lcg_tb_pkg.sv
// transaction types and shadow-model scoreboard for the locomotion command gate bench
`timescale 1ns / 1ps
package lcg_tb_pkg;
    import lcg_pkg::*;

    localparam int VW = VEL_BITS_DEF;
    localparam int TW = TICK_BITS_DEF;

    typedef struct packed {
        logic [OP_BITS-1:0]          op;
        logic                        reply_ok;
        logic signed [MODE_BITS-1:0] mode_id;
        logic signed [MODE_BITS-1:0] mode_sub;
        logic                        cmd_enable;
        logic                        cmd_continuous;
        logic [DUR_BITS-1:0]         cmd_duration;
        logic signed [VW-1:0]        forward_in;
        logic signed [VW-1:0]        side_in;
        logic signed [VW-1:0]        turn_in;
    } gate_event_t;

    typedef struct packed {
        logic [ACT_BITS-1:0]         action;
        logic signed [VW-1:0]        forward_out;
        logic signed [VW-1:0]        side_out;
        logic signed [VW-1:0]        turn_out;
        logic [DUR_BITS-1:0]         duration_out;
        logic [VERD_BITS-1:0]        verdict;
        logic [PHASE_BITS-1:0]       init_phase;
        logic                        gate_ready;
        logic                        motion_active;
        logic signed [MODE_BITS-1:0] cached_mode_id;
        logic signed [MODE_BITS-1:0] cached_mode_sub;
    } gate_result_t;

    class gate_shadow;
        logic [LIM_BITS-1:0]         lim_forward;
        logic [LIM_BITS-1:0]         lim_side;
        logic [LIM_BITS-1:0]         lim_turn;
        logic [DUR_BITS-1:0]         stream_tmo;
        logic [DUR_BITS-1:0]         drive_dur;
        logic [FAIL_BITS-1:0]        fail_limit;
        logic [DUR_BITS-1:0]         stop_dur;

        logic [PHASE_BITS-1:0]       phase;
        bit                          ready_flag;
        bit                          iface_on;
        bit                          cmd_pending;
        bit                          motion_on;
        logic signed [VW-1:0]        held_forward;
        logic signed [VW-1:0]        held_side;
        logic signed [VW-1:0]        held_turn;
        logic [TW-1:0]               tick_clock;
        logic [TW-1:0]               last_cmd_tick;
        logic [TW-1:0]               deadline_tick;
        bit                          have_cmd_tick;
        bit                          deadline_set;
        logic [FAIL_BITS-1:0]        fail_count;
        logic signed [MODE_BITS-1:0] known_id;
        logic signed [MODE_BITS-1:0] known_sub;

        gate_result_t                queued_gate_results[$];
        int                          mismatch_count;

        function new();
            lim_forward   = RST_MAX_FORWARD;
            lim_side      = RST_MAX_SIDE;
            lim_turn      = RST_MAX_TURN;
            stream_tmo    = RST_STREAM_TMO;
            drive_dur     = RST_DRIVE_DUR;
            fail_limit    = RST_FAIL_LIMIT;
            stop_dur      = RST_STOP_DUR;
            phase         = PH_IDLE;
            ready_flag    = 0;
            iface_on      = 0;
            cmd_pending   = 0;
            motion_on     = 0;
            held_forward  = '0;
            held_side     = '0;
            held_turn     = '0;
            tick_clock    = '0;
            last_cmd_tick = '0;
            deadline_tick = '0;
            have_cmd_tick = 0;
            deadline_set  = 0;
            fail_count    = '0;
            known_id      = MODE_UNKNOWN;
            known_sub     = MODE_UNKNOWN;
            mismatch_count = 0;
        endfunction

        function void load_register(logic [CFG_IDX_BITS-1:0] idx,
                                    logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_MAX_FORWARD: lim_forward = data[LIM_BITS-1:0];
                REG_MAX_SIDE:    lim_side    = data[LIM_BITS-1:0];
                REG_MAX_TURN:    lim_turn    = data[LIM_BITS-1:0];
                REG_STREAM_TMO:  stream_tmo  = data[DUR_BITS-1:0];
                REG_DRIVE_DUR:   drive_dur   = data[DUR_BITS-1:0];
                REG_FAIL_LIMIT:  fail_limit  = data[FAIL_BITS-1:0];
                REG_STOP_DUR:    stop_dur    = data[DUR_BITS-1:0];
                default:         ;
            endcase
        endfunction

        function logic signed [VW-1:0] clamp_speed(logic signed [VW-1:0] v,
                                                   logic [LIM_BITS-1:0] lim);
            int lv = int'(lim);
            int iv = int'(v);
            if (iv > lv)
                return VW'(lv);
            if (iv < -lv)
                return VW'(-lv);
            return v;
        endfunction

        function void mark_ready();
            ready_flag = 1;
            phase      = PH_READY;
            fail_count = '0;
            known_id   = MODE_BITS'(TARGET_MODE_DEF);
            known_sub  = MODE_UNKNOWN;
        endfunction

        function void mark_error();
            ready_flag  = 0;
            cmd_pending = 0;
            motion_on   = 0;
            phase       = PH_ERROR;
            known_id    = MODE_UNKNOWN;
            known_sub   = MODE_UNKNOWN;
        endfunction

        // bring-up is ignored while a handshake with the base is in flight
        function bit begin_init();
            if (phase == PH_CHECKING || phase == PH_SETTING || phase == PH_VERIFYING)
                return 0;
            ready_flag  = 0;
            cmd_pending = 0;
            motion_on   = 0;
            phase       = PH_CHECKING;
            return 1;
        endfunction

        function gate_result_t predict_gate_result(gate_event_t e);
            gate_result_t r;
            logic [TW-1:0] elapsed;
            logic [TW-1:0] shot_span;
            logic [DUR_BITS-1:0] d;
            bit stream_out;
            bit shot_out;
            bit id_is_target;
            r = '0;
            id_is_target = (int'(e.mode_id) == TARGET_MODE_DEF);
            case (e.op)
                OP_TICK:
                begin
                    tick_clock = tick_clock + 1'b1;
                    if (ready_flag && iface_on && cmd_pending)
                    begin
                        elapsed    = tick_clock - last_cmd_tick;
                        shot_span  = deadline_tick - last_cmd_tick;
                        stream_out = have_cmd_tick && (elapsed > TW'(stream_tmo));
                        shot_out   = deadline_set && (elapsed > shot_span);
                        if (stream_out || shot_out)
                        begin
                            cmd_pending    = 0;
                            motion_on      = 0;
                            r.action       = ACT_ZERO_STOP;
                            r.duration_out = stop_dur;
                        end
                        else
                        begin
                            r.action       = ACT_SEND_VEL;
                            r.forward_out  = held_forward;
                            r.side_out     = held_side;
                            r.turn_out     = held_turn;
                            r.duration_out = drive_dur;
                        end
                    end
                end
                OP_ENABLE:
                begin
                    iface_on = 1;
                    if (!ready_flag && begin_init())
                        r.action = ACT_QUERY;
                end
                OP_DISABLE:
                begin
                    cmd_pending = 0;
                    motion_on   = 0;
                    iface_on    = 0;
                    r.action    = ACT_STOP_MOVE;
                end
                OP_COMMAND:
                begin
                    if (!e.cmd_enable)
                        r.verdict = VERD_ENABLE_FALSE;
                    else if (!iface_on)
                        r.verdict = VERD_IF_DISABLED;
                    else if (!ready_flag)
                        r.verdict = VERD_NOT_READY;
                    else
                    begin
                        d = (e.cmd_duration == '0) ? DUR_BITS'(1) : e.cmd_duration;
                        held_forward  = clamp_speed(e.forward_in, lim_forward);
                        held_side     = clamp_speed(e.side_in, lim_side);
                        held_turn     = clamp_speed(e.turn_in, lim_turn);
                        last_cmd_tick = tick_clock;
                        have_cmd_tick = 1;
                        deadline_set  = !e.cmd_continuous;
                        deadline_tick = deadline_set ? (tick_clock + TW'(d)) : '0;
                        cmd_pending   = 1;
                        motion_on     = (held_forward != 0) || (held_side != 0) ||
                                        (held_turn != 0);
                    end
                end
                OP_STOP:
                begin
                    cmd_pending = 0;
                    motion_on   = 0;
                    r.action    = ACT_STOP_MOVE;
                end
                OP_INIT:
                begin
                    if (begin_init())
                        r.action = ACT_QUERY;
                end
                OP_ID_REPLY:
                begin
                    if (phase == PH_CHECKING)
                    begin
                        if (!e.reply_ok)
                            mark_error();
                        else if (id_is_target)
                            mark_ready();
                        else
                        begin
                            phase    = PH_SETTING;
                            known_id = e.mode_id;
                            r.action = ACT_SET_MODE;
                        end
                    end
                    else if (phase == PH_VERIFYING)
                    begin
                        if (!e.reply_ok || !id_is_target)
                            mark_error();
                        else
                            mark_ready();
                    end
                end
                OP_SET_REPLY:
                begin
                    if (phase == PH_SETTING)
                    begin
                        if (!e.reply_ok)
                            mark_error();
                        else
                        begin
                            phase    = PH_VERIFYING;
                            r.action = ACT_QUERY;
                        end
                    end
                end
                OP_VEL_REPLY:
                begin
                    if (e.reply_ok)
                        fail_count = '0;
                    else
                    begin
                        if (fail_count < FAIL_SAT)
                            fail_count = fail_count + 1'b1;
                        if (fail_count >= fail_limit && ready_flag)
                        begin
                            mark_error();
                            r.action       = ACT_ZERO_STOP;
                            r.duration_out = stop_dur;
                        end
                    end
                end
                OP_QUERY:
                begin
                    if (e.reply_ok)
                    begin
                        ready_flag = id_is_target;
                        phase      = ready_flag ? PH_READY : PH_ERROR;
                        known_id   = e.mode_id;
                        known_sub  = e.mode_sub;
                    end
                    else
                    begin
                        ready_flag = 0;
                        phase      = PH_ERROR;
                        known_id   = MODE_UNKNOWN;
                        known_sub  = MODE_UNKNOWN;
                    end
                end
                default: ;
            endcase
            r.init_phase      = phase;
            r.gate_ready      = ready_flag;
            r.motion_active   = motion_on;
            r.cached_mode_id  = known_id;
            r.cached_mode_sub = known_sub;
            return r;
        endfunction

        function void note_event(gate_event_t e);
            queued_gate_results.push_back(predict_gate_result(e));
        endfunction

        function void compare_field(string name, logic signed [31:0] want_v,
                                    logic signed [31:0] got_v);
            if (got_v !== want_v)
            begin
                $error("%s: expected %0d, got %0d", name, want_v, got_v);
                mismatch_count++;
            end
        endfunction

        function void check_result(gate_result_t got);
            gate_result_t want;
            if (queued_gate_results.size() == 0)
            begin
                $error("result transaction with no event outstanding, action %0d",
                       got.action);
                mismatch_count++;
                return;
            end
            want = queued_gate_results.pop_front();
            compare_field("action", want.action, got.action);
            compare_field("forward_out", want.forward_out, got.forward_out);
            compare_field("side_out", want.side_out, got.side_out);
            compare_field("turn_out", want.turn_out, got.turn_out);
            compare_field("duration_out", want.duration_out, got.duration_out);
            compare_field("verdict", want.verdict, got.verdict);
            compare_field("init_phase", want.init_phase, got.init_phase);
            compare_field("gate_ready", want.gate_ready, got.gate_ready);
            compare_field("motion_active", want.motion_active, got.motion_active);
            compare_field("cached_mode_id", want.cached_mode_id, got.cached_mode_id);
            compare_field("cached_mode_sub", want.cached_mode_sub, got.cached_mode_sub);
        endfunction
    endclass

endpackage

FILE: dv/tb_locomotion_command_gate.sv
// testbench top for the locomotion command gate: directed and random events against a shadow model
`timescale 1ns / 1ps
module tb_locomotion_command_gate;
    import lcg_pkg::*;
    import lcg_tb_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic       clk;
    logic       rst_n;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         results_seen;
    int         stall_left;
    int         cycle_count;
    gate_shadow shadow;

    lcg_evt_if evt_ch ();
    lcg_res_if res_ch ();
    lcg_cfg_if cfg_ch ();

    locomotion_command_gate uut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic gate_event_t quiet_event(logic [OP_BITS-1:0] op);
        gate_event_t e;
        e = '0;
        e.op = op;
        return e;
    endfunction

    function automatic gate_event_t reply_event(logic [OP_BITS-1:0] op, logic ok,
                                                int mid, int msub);
        gate_event_t e;
        e = '0;
        e.op       = op;
        e.reply_ok = ok;
        e.mode_id  = MODE_BITS'(mid);
        e.mode_sub = MODE_BITS'(msub);
        return e;
    endfunction

    function automatic gate_event_t command_event(logic en, logic cont, int dur,
                                                  int fwd, int side, int turn);
        gate_event_t e;
        e = '0;
        e.op             = OP_COMMAND;
        e.cmd_enable     = en;
        e.cmd_continuous = cont;
        e.cmd_duration   = DUR_BITS'(dur);
        e.forward_in     = VW'(fwd);
        e.side_in        = VW'(side);
        e.turn_in        = VW'(turn);
        return e;
    endfunction

    function automatic logic signed [VW-1:0] random_velocity();
        int pick;
        pick = $urandom_range(99);
        if (pick < 30)
            return VW'($urandom);
        if (pick < 70)
            return VW'(int'($urandom_range(0, 2000)) - 1000);
        if (pick < 85)
            return '0;
        return pick[0] ? VW'(32767) : VW'(-32768);
    endfunction

    // mostly well-formed traffic for the current bring-up phase, some noise
    function automatic gate_event_t next_random_event();
        gate_event_t e;
        int pick;
        e.reply_ok       = ($urandom_range(99) < 85);
        e.mode_id        = ($urandom_range(99) < 50) ? MODE_BITS'(TARGET_MODE_DEF)
                                                     : MODE_BITS'($urandom);
        e.mode_sub       = MODE_BITS'($urandom);
        e.cmd_enable     = ($urandom_range(99) < 90);
        e.cmd_continuous = 1'($urandom_range(1));
        e.cmd_duration   = ($urandom_range(99) < 80) ? DUR_BITS'($urandom_range(0, 6))
                                                     : DUR_BITS'($urandom);
        e.forward_in     = random_velocity();
        e.side_in        = random_velocity();
        e.turn_in        = random_velocity();
        e.op             = OP_BITS'($urandom_range(0, 15));
        pick = $urandom_range(99);
        if (pick >= 8)
        begin
            case (shadow.phase)
                PH_CHECKING:
                    e.op = (pick < 75) ? OP_ID_REPLY : (pick < 88) ? OP_TICK : OP_SET_REPLY;
                PH_SETTING:
                    e.op = (pick < 75) ? OP_SET_REPLY : (pick < 88) ? OP_ID_REPLY : OP_TICK;
                PH_VERIFYING:
                begin
                    e.op = (pick < 75) ? OP_ID_REPLY : (pick < 88) ? OP_TICK : OP_VEL_REPLY;
                    if ($urandom_range(99) < 85)
                        e.mode_id = MODE_BITS'(TARGET_MODE_DEF);
                end
                PH_READY:
                begin
                    if (!shadow.iface_on && pick < 60)
                        e.op = OP_ENABLE;
                    else if (pick < 45)
                        e.op = OP_COMMAND;
                    else if (pick < 75)
                        e.op = OP_TICK;
                    else if (pick < 85)
                    begin
                        e.op = OP_VEL_REPLY;
                        e.reply_ok = ($urandom_range(99) < 70);
                    end
                    else if (pick < 88)
                        e.op = OP_STOP;
                    else if (pick < 91)
                        e.op = OP_DISABLE;
                    else if (pick < 95)
                    begin
                        e.op = OP_QUERY;
                        if ($urandom_range(99) < 80)
                            e.mode_id = MODE_BITS'(TARGET_MODE_DEF);
                    end
                    else if (pick < 97)
                        e.op = OP_INIT;
                    else
                        e.op = OP_ENABLE;
                end
                default:
                    e.op = (pick < 50) ? OP_ENABLE : (pick < 80) ? OP_INIT : OP_QUERY;
            endcase
        end
        return e;
    endfunction

    task automatic send_event(input gate_event_t e);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            evt_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        evt_ch.valid          <= 1'b1;
        evt_ch.op             <= e.op;
        evt_ch.reply_ok       <= e.reply_ok;
        evt_ch.mode_id        <= e.mode_id;
        evt_ch.mode_sub       <= e.mode_sub;
        evt_ch.cmd_enable     <= e.cmd_enable;
        evt_ch.cmd_continuous <= e.cmd_continuous;
        evt_ch.cmd_duration   <= e.cmd_duration;
        evt_ch.forward_in     <= e.forward_in;
        evt_ch.side_in        <= e.side_in;
        evt_ch.turn_in        <= e.turn_in;
        @(posedge clk);
        while (!evt_ch.ready)
            @(posedge clk);
        shadow.note_event(e);
    endtask

    task automatic drain_results();
        evt_ch.valid <= 1'b0;
        while (shadow.queued_gate_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx, input int value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= CFG_DATA_BITS'(value);
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        shadow.load_register(idx, CFG_DATA_BITS'(value));
    endtask

    task automatic program_limits(input int fwd, input int side, input int turn,
                                  input int tmo, input int drive, input int fail_lim,
                                  input int stop);
        write_register(REG_MAX_FORWARD, fwd);
        write_register(REG_MAX_SIDE, side);
        write_register(REG_MAX_TURN, turn);
        write_register(REG_STREAM_TMO, tmo);
        write_register(REG_DRIVE_DUR, drive);
        write_register(REG_FAIL_LIMIT, fail_lim);
        write_register(REG_STOP_DUR, stop);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++)
        begin
            // hold the sender once until the gate has answered everything
            if (n == count / 2)
                drain_results();
            send_event(next_random_event());
        end
    endtask

    // result sink: checks each transaction, random backpressure, long hold-offs
    initial
    begin : result_sink
        gate_result_t got;
        results_seen = 0;
        stall_left   = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
            begin
                got.action          = res_ch.action;
                got.forward_out     = res_ch.forward_out;
                got.side_out        = res_ch.side_out;
                got.turn_out        = res_ch.turn_out;
                got.duration_out    = res_ch.duration_out;
                got.verdict         = res_ch.verdict;
                got.init_phase      = res_ch.init_phase;
                got.gate_ready      = res_ch.gate_ready;
                got.motion_active   = res_ch.motion_active;
                got.cached_mode_id  = res_ch.cached_mode_id;
                got.cached_mode_sub = res_ch.cached_mode_sub;
                shadow.check_result(got);
                results_seen++;
                if (results_seen == 60 || results_seen == 300)
                    stall_left = 50;
            end
            if (!rst_n)
                res_ch.ready <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin : run_watchdog
        cycle_count = 0;
        while (cycle_count <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        shadow        = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n                 <= 1'b0;
        evt_ch.valid          <= 1'b0;
        evt_ch.op             <= OP_TICK;
        evt_ch.reply_ok       <= 1'b0;
        evt_ch.mode_id        <= '0;
        evt_ch.mode_sub       <= '0;
        evt_ch.cmd_enable     <= 1'b0;
        evt_ch.cmd_continuous <= 1'b0;
        evt_ch.cmd_duration   <= '0;
        evt_ch.forward_in     <= '0;
        evt_ch.side_in        <= '0;
        evt_ch.turn_in        <= '0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.index          <= REG_MAX_FORWARD;
        cfg_ch.data           <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // rejections before bring-up, stale reply in idle
        send_event(command_event(1'b1, 1'b1, 5, 100, 100, 100));
        send_event(command_event(1'b0, 1'b1, 5, 100, 100, 100));
        send_event(reply_event(OP_ID_REPLY, 1'b1, TARGET_MODE_DEF, 0));
        // full bring-up through set mode, with busy and stale events
        send_event(quiet_event(OP_ENABLE));
        send_event(command_event(1'b1, 1'b1, 5, 100, 100, 100));
        send_event(quiet_event(OP_INIT));
        send_event(reply_event(OP_ID_REPLY, 1'b1, 7, 0));
        send_event(reply_event(OP_ID_REPLY, 1'b1, TARGET_MODE_DEF, 0));
        send_event(reply_event(OP_SET_REPLY, 1'b1, 0, 0));
        send_event(reply_event(OP_ID_REPLY, 1'b1, TARGET_MODE_DEF, 0));
        // one-shot with zero duration and clamped extremes, then its deadline
        send_event(command_event(1'b1, 1'b0, 0, 32767, -32768, 799));
        send_event(quiet_event(OP_TICK));
        send_event(quiet_event(OP_TICK));
        send_event(command_event(1'b1, 1'b1, 65535, -32768, 32767, -32768));
        // failure counter reset and gate closing
        send_event(reply_event(OP_VEL_REPLY, 1'b0, 0, 0));
        send_event(reply_event(OP_VEL_REPLY, 1'b1, 0, 0));
        send_event(reply_event(OP_VEL_REPLY, 1'b0, 0, 0));
        send_event(reply_event(OP_VEL_REPLY, 1'b0, 0, 0));
        send_event(reply_event(OP_VEL_REPLY, 1'b0, 0, 0));
        send_event(reply_event(OP_QUERY, 1'b1, TARGET_MODE_DEF, -32768));
        send_event(reply_event(OP_QUERY, 1'b0, 32767, 32767));
        send_event(quiet_event(OP_STOP));
        send_event(quiet_event(OP_DISABLE));
        send_event(quiet_event(4'hF));
        drain_results();

        program_limits(32767, 0, 1, 1, 65535, 1, 65535);
        send_idle_pct = 38;
        recv_idle_pct = 83;
        run_random(170);
        drain_results();

        program_limits(0, 32767, 12345, 65535, 0, 255, 0);
        send_idle_pct = 83;
        recv_idle_pct = 38;
        run_random(170);
        drain_results();

        program_limits($urandom_range(0, 32767), $urandom_range(0, 32767),
                       $urandom_range(0, 32767), $urandom_range(0, 12),
                       $urandom_range(0, 65535), $urandom_range(0, 5),
                       $urandom_range(0, 65535));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(170);
        drain_results();
        repeat (8) @(posedge clk);

        if (shadow.mismatch_count == 0 && shadow.queued_gate_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
